@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante, sampled on clk, off during reset.
`define ILID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilid assertion failed");

// Check cons in the cycle after ante.
`define ILID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilid assertion failed");

`endif

@@ rtl/ilid_pkg.sv @@
package ilid_pkg;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned ST_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_DUMP = 2'd2
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL,
        OP_ROT
    } cell_op_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        cell_op_t                  op;
        logic [CNT_W-1:0]          p0;        // zero-based target place
        logic [CNT_W-1:0]          last_idx;  // place of the last held entry
        logic signed [DATA_W-1:0]  value;
    } cell_ctl_t;

endpackage

@@ rtl/ilid_req_if.sv @@
interface ilid_req_if;
    logic                              valid;
    logic                              ready;
    logic [ilid_pkg::CMD_W-1:0]        cmd;
    logic [ilid_pkg::POS_W-1:0]        position;
    logic signed [ilid_pkg::DATA_W-1:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

@@ rtl/ilid_res_if.sv @@
interface ilid_res_if;
    logic                              valid;
    logic                              ready;
    logic [ilid_pkg::ST_W-1:0]         status;
    logic signed [ilid_pkg::DATA_W-1:0] element;
    logic                              last;
    logic [ilid_pkg::CNT_W-1:0]        count;

    modport source (output valid, output status, output element, output last, output count,
                    input ready);
    modport sink   (input valid, input status, input element, input last, input count,
                    output ready);
endinterface

@@ rtl/indexed_list_insert_delete.sv @@
// Insert and delete: result word valid in the cycle after the command is taken.
// Dump of n entries: enters S_DUMP, then one word per cycle while results are taken;
// a command is taken only once the previous dump has streamed out its last word.
// Throughput: one insert or delete per cycle while results are taken; the cell chain
// shifts the entries from the target on at once. Reset (rst_n low, asynchronous)
// empties the list and drops any pending result word; entry contents are not cleared.
module indexed_list_insert_delete #(
    parameter int unsigned DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    ilid_req_if.sink   request,
    ilid_res_if.source result
);
    import ilid_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic                     ovalid_reg, ovalid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] element_reg, element_next;
    logic                     last_reg, last_next;
    logic [CNT_W-1:0]         ocount_reg, ocount_next;

    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] cell_q [DEPTH];
    logic signed [DATA_W-1:0] cell_pick [DEPTH];
    logic signed [DATA_W-1:0] picked;
    logic                     slot_free;
    logic                     accept;
    logic                     ins_ok;
    logic                     del_ok;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_w;
            logic signed [DATA_W-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = cell_q[0];
            end
            else
            begin : g_mid_l
                assign left_w = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_end
                assign right_w = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_w = cell_q[gi+1];
            end
            ilid_cell #(.IDX(gi)) u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .left  (left_w),
                .right (right_w),
                .head  (cell_q[0]),
                .data  (cell_q[gi]),
                .pick  (cell_pick[gi])
            );
        end
    endgenerate

    // only the target cell drives a nonzero pick
    always_comb
    begin
        picked = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            picked = picked | cell_pick[i];
        end
    end

    assign slot_free     = !ovalid_reg || result.ready;
    assign request.ready = (state_reg == S_IDLE) && slot_free;
    assign accept        = request.valid && request.ready;

    assign ins_ok = (request.position != '0) &&
                    ({1'b0, request.position} <= ({1'b0, count_reg} + 8'd1));
    assign del_ok = (request.position != '0) && (request.position <= count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        ovalid_next  = ovalid_reg && !result.ready;
        status_next  = status_reg;
        element_next = element_reg;
        last_next    = last_reg;
        ocount_next  = ocount_reg;

        ctl.op       = OP_HOLD;
        ctl.p0       = request.position - 7'd1;
        ctl.last_idx = count_reg - 7'd1;
        ctl.value    = request.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (request.cmd)
                        CMD_INS:
                        begin
                            ovalid_next  = 1'b1;
                            element_next = request.value;
                            last_next    = 1'b1;
                            ocount_next  = count_reg;
                            if (!ins_ok)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (count_reg >= DEPTH_C)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                ctl.op      = OP_INS;
                                count_next  = count_reg + 7'd1;
                                ocount_next = count_reg + 7'd1;
                            end
                        end
                        CMD_DEL:
                        begin
                            ovalid_next = 1'b1;
                            last_next   = 1'b1;
                            ocount_next = count_reg;
                            if (!del_ok)
                            begin
                                status_next  = ST_RANGE;
                                element_next = '0;
                            end
                            else
                            begin
                                status_next  = ST_OK;
                                element_next = picked;
                                ctl.op       = OP_DEL;
                                count_next   = count_reg - 7'd1;
                                ocount_next  = count_reg - 7'd1;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                ovalid_next  = 1'b1;
                                status_next  = ST_EMPTY;
                                element_next = '0;
                                last_next    = 1'b1;
                                ocount_next  = '0;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                k_next     = '0;
                            end
                        end
                        default:
                        begin
                            // unused command: drop the word
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    ovalid_next  = 1'b1;
                    status_next  = ST_OK;
                    element_next = cell_q[0];
                    last_next    = (k_reg == ctl.last_idx);
                    ocount_next  = count_reg;
                    ctl.op       = OP_ROT;
                    k_next       = k_reg + 7'd1;
                    if (k_reg == ctl.last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            ovalid_reg  <= 1'b0;
            status_reg  <= ST_OK;
            element_reg <= '0;
            last_reg    <= 1'b0;
            ocount_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            ovalid_reg  <= ovalid_next;
            status_reg  <= status_next;
            element_reg <= element_next;
            last_reg    <= last_next;
            ocount_reg  <= ocount_next;
        end
    end

    assign result.valid   = ovalid_reg;
    assign result.status  = status_reg;
    assign result.element = element_reg;
    assign result.last    = last_reg;
    assign result.count   = ocount_reg;

endmodule

@@ rtl/ilid_cell.sv @@
module ilid_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                               clk,
    input  ilid_pkg::cell_ctl_t                ctl,
    input  logic signed [ilid_pkg::DATA_W-1:0] left,
    input  logic signed [ilid_pkg::DATA_W-1:0] right,
    input  logic signed [ilid_pkg::DATA_W-1:0] head,
    output logic signed [ilid_pkg::DATA_W-1:0] data,
    output logic signed [ilid_pkg::DATA_W-1:0] pick
);
    import ilid_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_INS:
            begin
                // open a gap at the target place, move later words up
                if (IDX_C > ctl.p0)
                begin
                    data_next = left;
                end
                else if (IDX_C == ctl.p0)
                begin
                    data_next = ctl.value;
                end
            end
            OP_DEL:
            begin
                if (IDX_C >= ctl.p0)
                begin
                    data_next = right;
                end
            end
            OP_ROT:
            begin
                // rotate the held words by one, head wraps to the tail
                if (IDX_C < ctl.last_idx)
                begin
                    data_next = right;
                end
                else if (IDX_C == ctl.last_idx)
                begin
                    data_next = head;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign pick = (IDX_C == ctl.p0) ? data_reg : '0;

endmodule

@@ rtl/ilid_checker.sv @@
`include "assert_macros.svh"

module ilid_checker #(
    parameter int unsigned DEPTH = 64
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic [ilid_pkg::ST_W-1:0]          res_status,
    input logic signed [ilid_pkg::DATA_W-1:0] res_element,
    input logic                               res_last,
    input logic [ilid_pkg::CNT_W-1:0]         res_count
);
    import ilid_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // a stalled result word holds until taken
    `ILID_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_element) && $stable(res_status) && $stable(res_last) && $stable(res_count))

    `ILID_ASSERT_NOW(a_count_cap, res_valid, res_count <= DEPTH_C)

    `ILID_ASSERT_NOW(a_full_count, res_valid && res_status == ST_FULL, res_count == DEPTH_C)

    `ILID_ASSERT_NOW(a_empty_word, res_valid && res_status == ST_EMPTY, res_count == '0 && res_last && res_element == '0)

endmodule

bind indexed_list_insert_delete ilid_checker #(.DEPTH(DEPTH)) u_ilid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_status  (result.status),
    .res_element (result.element),
    .res_last    (result.last),
    .res_count   (result.count)
);
